// ----- sv/llrf_pkg.sv -----
// ----------------------------------------------------------------------------
// llrf_pkg
// Shared types and constants for the longest literal run finder: beat
// layouts, the classified byte that the front passes to the back, status
// codes and the special characters of the pattern syntax.
// ----------------------------------------------------------------------------
package llrf_pkg;

  // Special characters of the pattern syntax.
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_LBRACKET  = 8'h5B;
  localparam logic [7:0] CH_RBRACKET  = 8'h5D;
  localparam logic [7:0] CH_BAR       = 8'h7C;
  localparam logic [7:0] CH_LPAREN    = 8'h28;
  localparam logic [7:0] CH_RPAREN    = 8'h29;
  localparam logic [7:0] CH_QUESTION  = 8'h3F;
  localparam logic [7:0] CH_STAR      = 8'h2A;
  localparam logic [7:0] CH_LBRACE    = 8'h7B;
  localparam logic [7:0] CH_RBRACE    = 8'h7D;
  localparam logic [7:0] CH_DOT       = 8'h2E;
  localparam logic [7:0] CH_PLUS      = 8'h2B;
  localparam logic [7:0] CH_CARET     = 8'h5E;
  localparam logic [7:0] CH_DOLLAR    = 8'h24;
  localparam logic [7:0] CH_SLASH     = 8'h2F;

  // Width of the threshold register.
  localparam int unsigned MinLenWidth = 11;

  // Depth of the queue between front and back.
  localparam int unsigned QueueDepth = 2;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_FOUND       = 2'd0,
    ST_ALTERNATION = 2'd1,
    ST_TOO_SHORT   = 2'd2,
    ST_TOO_LONG    = 2'd3
  } status_t;

  // Input beat: one pattern byte.
  typedef struct packed {
    logic [7:0] pattern_byte;
    logic       is_regex;
    logic       last_byte;
  } in_beat_t;

  // Output beat: one result per pattern.
  typedef struct packed {
    status_t     status;
    logic [9:0]  run_offset;
    logic [10:0] run_length;
  } out_beat_t;

  // Classified byte. Regex-only flags are already gated with the mode.
  typedef struct packed {
    logic rx;        // regex mode
    logic last;      // final byte of the pattern
    logic escape;    // regex backslash
    logic cls_open;  // regex '['
    logic cls_close; // regex ']'
    logic bar;       // regex '|'
    logic grp_open;  // regex '('
    logic grp_close; // regex ')'
    logic brk;       // break character in the current mode
    logic drop;      // regex '?', '*' or '{': drop the last run byte
  } op_t;

endpackage

// ----- sv/llrf_front.sv -----
// ----------------------------------------------------------------------------
// llrf_front
// Accepts pattern bytes and classifies each one into an op for the back end.
// A byte is taken whenever the queue has room.
// ----------------------------------------------------------------------------
module llrf_front (
  input  logic              in_valid,
  output logic              in_ready,
  input  llrf_pkg::in_beat_t in_data,
  input  logic              q_full,
  output logic              q_push,
  output llrf_pkg::op_t     q_op
);
  import llrf_pkg::*;

  logic [7:0] c;
  logic       rx;
  logic       brk_any;
  logic       brk_rx;

  // Handshake toward the queue.
  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  assign c  = in_data.pattern_byte;
  assign rx = in_data.is_regex;

  // Break characters in both modes and in regex mode only.
  assign brk_any = (c == CH_DOT) || (c == CH_QUESTION) || (c == CH_STAR) ||
                   (c == CH_PLUS) || (c == CH_CARET) || (c == CH_DOLLAR);
  assign brk_rx  = (c == CH_BAR) || (c == CH_SLASH) || (c == CH_LPAREN) ||
                   (c == CH_RPAREN) || (c == CH_LBRACKET) || (c == CH_RBRACKET) ||
                   (c == CH_LBRACE) || (c == CH_RBRACE);

  // Build the op.
  always_comb begin
    q_op           = '0;
    q_op.rx        = rx;
    q_op.last      = in_data.last_byte;
    q_op.escape    = rx && (c == CH_BACKSLASH);
    q_op.cls_open  = rx && (c == CH_LBRACKET);
    q_op.cls_close = rx && (c == CH_RBRACKET);
    q_op.bar       = rx && (c == CH_BAR);
    q_op.grp_open  = rx && (c == CH_LPAREN);
    q_op.grp_close = rx && (c == CH_RPAREN);
    q_op.brk       = brk_any || (rx && brk_rx);
    q_op.drop      = rx && ((c == CH_QUESTION) || (c == CH_STAR) || (c == CH_LBRACE));
  end

endmodule

// ----- sv/llrf_queue.sv -----
// ----------------------------------------------------------------------------
// llrf_queue
// Small register queue of classified ops between front and back, so each
// side can stall on its own.
// ----------------------------------------------------------------------------
module llrf_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  llrf_pkg::op_t push_op,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output llrf_pkg::op_t head_op
);
  import llrf_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  op_t             slots [QueueDepth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign full      = (count == CntW'(QueueDepth));
  assign not_empty = (count != '0);
  assign head_op   = slots[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Slot storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_op;
    end
  end

endmodule

// ----- sv/llrf_back.sv -----
// ----------------------------------------------------------------------------
// llrf_back
// Executes classified ops against the run tracking state, one per cycle unless
// a final byte meets a busy result slot; each result is held in an output register.
// ----------------------------------------------------------------------------
module llrf_back #(
  parameter int unsigned MAX_LEN = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [10:0]         cfg_data,
  input  logic                q_not_empty,
  input  llrf_pkg::op_t       q_head,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output llrf_pkg::out_beat_t out_data
);
  import llrf_pkg::*;

  // Position, lengths and depth can all reach MAX_LEN; offsets stay below it.
  localparam int unsigned LenW = $clog2(MAX_LEN + 1);
  localparam int unsigned OffW = $clog2(MAX_LEN);
  localparam logic [LenW-1:0] MaxPos = LenW'(MAX_LEN);

  logic [MinLenWidth-1:0] min_run_length;
  logic [LenW-1:0]        byte_position, byte_position_next;
  logic [OffW-1:0]        current_offset, current_offset_next;
  logic [LenW-1:0]        current_length, current_length_next;
  logic [OffW-1:0]        best_offset, best_offset_next;
  logic [LenW-1:0]        best_length, best_length_next;
  logic                   inside_class, inside_class_next;
  logic [LenW-1:0]        group_depth, group_depth_next;
  logic                   skip_next, skip_next_next;
  logic                   alternation_seen, alternation_seen_next;
  logic                   overflowed, overflowed_next;
  logic                   out_valid_next;
  out_beat_t              out_data_next;

  logic                   close_en;
  logic [LenW-1:0]        close_len;
  logic [LenW-1:0]        final_len;
  logic [OffW-1:0]        final_off;
  logic [LenW+MinLenWidth-1:0] cmp_best;
  logic [LenW+MinLenWidth-1:0] cmp_min;
  logic [OffW+9:0]        off_wide;
  logic [LenW+10:0]       len_wide;

  // An op leaves the queue unless it is a final byte and the result slot is busy.
  assign q_pop = q_not_empty && (!q_head.last || !out_valid || out_ready);

  // Per-byte state update.
  always_comb begin
    byte_position_next    = byte_position;
    current_offset_next   = current_offset;
    current_length_next   = current_length;
    best_offset_next      = best_offset;
    best_length_next      = best_length;
    inside_class_next     = inside_class;
    group_depth_next      = group_depth;
    skip_next_next        = skip_next;
    alternation_seen_next = alternation_seen;
    overflowed_next       = overflowed;
    close_en              = 1'b0;
    close_len             = current_length;

    if (q_pop && !alternation_seen && !overflowed) begin
      if (byte_position == MaxPos) begin
        overflowed_next = 1'b1;
      end else begin
        byte_position_next = byte_position + 1'b1;
        if (skip_next) begin
          skip_next_next = 1'b0;
        end else if (q_head.escape) begin
          close_en       = 1'b1;
          skip_next_next = 1'b1;
        end else if (q_head.bar && !inside_class) begin
          alternation_seen_next = 1'b1;
        end else begin
          // Class and group tracking.
          if (q_head.cls_open) begin
            inside_class_next = 1'b1;
          end else if (q_head.cls_close) begin
            inside_class_next = 1'b0;
          end else if (q_head.grp_open && !inside_class) begin
            group_depth_next = group_depth + 1'b1;
          end else if (q_head.grp_close && !inside_class && group_depth != '0) begin
            group_depth_next = group_depth - 1'b1;
          end
          // Break, grouped byte, or literal.
          if (q_head.brk) begin
            close_en = 1'b1;
            if (q_head.drop && current_length != '0) begin
              close_len = current_length - 1'b1;
            end
          end else if (q_head.rx && group_depth_next != '0) begin
            close_en = 1'b1;
          end else begin
            if (current_length == '0) begin
              current_offset_next = byte_position[OffW-1:0];
            end
            current_length_next = current_length + 1'b1;
          end
        end
      end
    end

    // Close the current run and keep it if strictly longer.
    if (close_en) begin
      if (close_len > best_length) begin
        best_length_next = close_len;
        best_offset_next = current_offset;
      end
      current_length_next = '0;
    end
  end

  // Final close of the open run at the end of the pattern.
  always_comb begin
    if (current_length_next > best_length_next) begin
      final_len = current_length_next;
      final_off = current_offset_next;
    end else begin
      final_len = best_length_next;
      final_off = best_offset_next;
    end
    cmp_best = {{MinLenWidth{1'b0}}, final_len};
    cmp_min  = {{LenW{1'b0}}, min_run_length};
    off_wide = {10'd0, final_off};
    len_wide = {11'd0, final_len};
  end

  // Result assembly and output slot control.
  always_comb begin
    out_valid_next = out_valid && !out_ready;
    out_data_next  = out_data;
    if (q_pop && q_head.last) begin
      out_valid_next           = 1'b1;
      out_data_next.run_offset = '0;
      out_data_next.run_length = '0;
      if (alternation_seen_next) begin
        out_data_next.status = ST_ALTERNATION;
      end else if (overflowed_next) begin
        out_data_next.status = ST_TOO_LONG;
      end else if (cmp_best < cmp_min) begin
        out_data_next.status = ST_TOO_SHORT;
      end else begin
        out_data_next.status     = ST_FOUND;
        out_data_next.run_offset = off_wide[9:0];
        out_data_next.run_length = len_wide[10:0];
      end
    end
  end

  // State registers; the pattern state clears after each final byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      min_run_length   <= MinLenWidth'(3);
      byte_position    <= '0;
      current_offset   <= '0;
      current_length   <= '0;
      best_offset      <= '0;
      best_length      <= '0;
      inside_class     <= 1'b0;
      group_depth      <= '0;
      skip_next        <= 1'b0;
      alternation_seen <= 1'b0;
      overflowed       <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      if (cfg_we) begin
        min_run_length <= cfg_data;
      end
      out_valid <= out_valid_next;
      if (q_pop && q_head.last) begin
        byte_position    <= '0;
        current_offset   <= '0;
        current_length   <= '0;
        best_offset      <= '0;
        best_length      <= '0;
        inside_class     <= 1'b0;
        group_depth      <= '0;
        skip_next        <= 1'b0;
        alternation_seen <= 1'b0;
        overflowed       <= 1'b0;
      end else begin
        byte_position    <= byte_position_next;
        current_offset   <= current_offset_next;
        current_length   <= current_length_next;
        best_offset      <= best_offset_next;
        best_length      <= best_length_next;
        inside_class     <= inside_class_next;
        group_depth      <= group_depth_next;
        skip_next        <= skip_next_next;
        alternation_seen <= alternation_seen_next;
        overflowed       <= overflowed_next;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    out_data <= out_data_next;
  end

endmodule

// ----- sv/longest_literal_run_finder.sv -----
// ----------------------------------------------------------------------------
// longest_literal_run_finder
// Finds the longest literal run of a filter pattern streamed one byte a beat.
// ----------------------------------------------------------------------------
// The block takes one pattern byte per cycle, back to back, while the queue
// has room, and returns one result beat per pattern, registered in the output
// register when the back end takes the final byte from the queue. A front
// end classifies each byte, a two-entry queue holds the classified bytes,
// and a back end updates the run state one byte a cycle; the back end's
// single state update per cycle sets the rate of one byte per cycle. The
// result waits in an output register, and input bytes keep flowing while it
// waits, until the queue fills behind a further final byte. min_run_length
// may be written only while no pattern is in flight.
module longest_literal_run_finder #(
  parameter int unsigned MAX_LEN = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  llrf_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output llrf_pkg::out_beat_t out_data,
  input  logic                cfg_we,
  input  logic [10:0]         cfg_data
);
  import llrf_pkg::*;

  logic q_full;
  logic q_push;
  logic q_pop;
  logic q_not_empty;
  op_t  q_op;
  op_t  q_head;

  // Byte classification.
  llrf_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_op     (q_op)
  );

  // Decoupling queue.
  llrf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_op   (q_op),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_op   (q_head)
  );

  // Run tracking and result.
  llrf_back #(
    .MAX_LEN (MAX_LEN)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule

// ----- tb/llrf_checker.sv -----
// ----------------------------------------------------------------------------
// llrf_checker
// Watches both channels and the threshold register of the longest literal
// run finder. Every pattern byte taken by the block is run through a model
// of the run search; each final byte queues the report the block must give.
// Reports that come out are compared field by field, in order.
// ----------------------------------------------------------------------------
module llrf_checker #(
  parameter int unsigned MAX_LEN = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_ready,
  input  llrf_pkg::in_beat_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  llrf_pkg::out_beat_t out_data,
  input  logic                cfg_we,
  input  logic [10:0]         cfg_data,
  output int unsigned         awaiting,
  output int unsigned         fail_count
);

  import llrf_pkg::*;

  // Copy of the threshold register and of the search state.
  logic [10:0] min_len;
  logic [10:0] scan_pos;
  logic [9:0]  run_start;
  logic [10:0] run_len;
  logic [9:0]  best_start;
  logic [10:0] best_len;
  logic        in_class;
  logic [10:0] depth;
  logic        escape_pending;
  logic        saw_bar;
  logic        too_long;

  // Reports owed by the block, oldest first.
  out_beat_t   reports_due[$];
  int unsigned errors = 0;

  // Forget everything about the pattern in progress.
  task automatic clear_pattern_state();
    scan_pos       = '0;
    run_start      = '0;
    run_len        = '0;
    best_start     = '0;
    best_len       = '0;
    in_class       = 1'b0;
    depth          = '0;
    escape_pending = 1'b0;
    saw_bar        = 1'b0;
    too_long       = 1'b0;
  endtask

  // End the current run, trimmed by drop bytes, and keep it if it is the
  // longest so far. A tie keeps the earlier run.
  task automatic close_run(input logic [10:0] drop);
    if (drop >= run_len) begin
      run_len = '0;
    end else begin
      run_len = run_len - drop;
    end
    if (run_len > best_len) begin
      best_len   = run_len;
      best_start = run_start;
    end
    run_len = '0;
  endtask

  // Apply one pattern byte that is inside the length limit.
  task automatic scan_byte(input logic [7:0] c, input logic rx);
    logic brk;
    logic drop_last;
    if (escape_pending) begin
      escape_pending = 1'b0;
      return;
    end
    if (rx) begin
      if (c == CH_BACKSLASH) begin
        close_run('0);
        escape_pending = 1'b1;
        return;
      end
      if (c == CH_LBRACKET) begin
        in_class = 1'b1;
      end else if (c == CH_RBRACKET) begin
        in_class = 1'b0;
      end else if (c == CH_BAR && !in_class) begin
        saw_bar = 1'b1;
        return;
      end else if (c == CH_LPAREN && !in_class) begin
        depth = depth + 11'd1;
      end else if (c == CH_RPAREN && !in_class && depth != '0) begin
        depth = depth - 11'd1;
      end
    end
    brk = (c == CH_DOT) || (c == CH_QUESTION) || (c == CH_STAR) ||
          (c == CH_PLUS) || (c == CH_CARET) || (c == CH_DOLLAR);
    if (rx && !brk) begin
      brk = (c == CH_BAR) || (c == CH_SLASH) || (c == CH_LPAREN) ||
            (c == CH_RPAREN) || (c == CH_LBRACKET) || (c == CH_RBRACKET) ||
            (c == CH_LBRACE) || (c == CH_RBRACE);
    end
    if (brk) begin
      drop_last = rx && ((c == CH_QUESTION) || (c == CH_STAR) || (c == CH_LBRACE));
      close_run(drop_last ? 11'd1 : 11'd0);
      return;
    end
    // Bytes inside a group are never part of a run.
    if (rx && depth != '0) begin
      close_run('0);
      return;
    end
    if (run_len == '0) begin
      run_start = scan_pos[9:0];
    end
    run_len = run_len + 11'd1;
  endtask

  // Advance the search by one accepted beat; a final byte yields a report.
  task automatic track_pattern_byte(input in_beat_t beat);
    out_beat_t rpt;
    if (!saw_bar && !too_long) begin
      if (scan_pos >= MAX_LEN) begin
        too_long = 1'b1;
      end else begin
        scan_byte(beat.pattern_byte, beat.is_regex);
        scan_pos = scan_pos + 11'd1;
      end
    end
    if (beat.last_byte) begin
      rpt = '0;
      if (saw_bar) begin
        rpt.status = ST_ALTERNATION;
      end else if (too_long) begin
        rpt.status = ST_TOO_LONG;
      end else begin
        close_run('0);
        if (best_len < min_len) begin
          rpt.status = ST_TOO_SHORT;
        end else begin
          rpt.status     = ST_FOUND;
          rpt.run_offset = best_start;
          rpt.run_length = best_len;
        end
      end
      reports_due.insert(reports_due.size(), rpt);
      clear_pattern_state();
    end
  endtask

  // Compare one result beat with the oldest report owed.
  task automatic check_report(input out_beat_t got);
    out_beat_t want;
    if (reports_due.size() == 0) begin
      $error("result beat with no report owed: status %0d offset %0d length %0d",
             got.status, got.run_offset, got.run_length);
      errors++;
      return;
    end
    want = reports_due.pop_front();
    if (got.status !== want.status) begin
      $error("status: expected %0d, actual %0d", want.status, got.status);
      errors++;
    end
    if (got.run_offset !== want.run_offset) begin
      $error("run_offset: expected %0d, actual %0d", want.run_offset, got.run_offset);
      errors++;
    end
    if (got.run_length !== want.run_length) begin
      $error("run_length: expected %0d, actual %0d", want.run_length, got.run_length);
      errors++;
    end
  endtask

  // Sample the channels at each edge, in the order the block sees them.
  always @(posedge clk) begin
    if (rst) begin
      min_len = 11'd3;
      clear_pattern_state();
      reports_due.delete();
    end else begin
      if (cfg_we) begin
        min_len = cfg_data;
      end
      if (out_valid && out_ready) begin
        check_report(out_data);
      end
      if (in_valid && in_ready) begin
        track_pattern_byte(in_data);
      end
    end
    awaiting   <= reports_due.size();
    fail_count <= errors;
  end

endmodule

// ----- tb/tb_longest_literal_run_finder.sv -----
// ----------------------------------------------------------------------------
// tb_longest_literal_run_finder
// Streams filter patterns into the longest literal run finder: a few
// hand-picked patterns, a back-pressure burst, then random patterns under
// several thresholds, including one pattern a byte over the length limit.
// The checker beside the block predicts and compares every report.
// ----------------------------------------------------------------------------
module tb_longest_literal_run_finder;

  import llrf_pkg::*;

  localparam int unsigned PERIOD       = 20;
  localparam int unsigned MAX_LEN      = 1024;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES  = 100;
  localparam int unsigned TIMEOUT      = PERIOD * 400000;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  in_beat_t    in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_beat_t   out_data;
  logic        cfg_we    = 1'b0;
  logic [10:0] cfg_data  = '0;

  int unsigned awaiting;
  int unsigned fail_count;

  // Idling switches and the handshake for the long receiver hold.
  bit tx_idle_on   = 1'b1;
  bit rx_idle_on   = 1'b1;
  bit hold_request = 1'b0;
  bit hold_active  = 1'b0;

  longest_literal_run_finder #(
    .MAX_LEN(MAX_LEN)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  llrf_checker #(
    .MAX_LEN(MAX_LEN)
  ) i_checker (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .awaiting  (awaiting),
    .fail_count(fail_count)
  );

  always #(PERIOD / 2) clk = ~clk;

  // Offer one beat, after an optional idle burst, and wait until it is taken.
  task automatic send_pattern_byte(input logic [7:0] c, input logic rx, input logic last);
    if (tx_idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid             <= 1'b1;
    in_data.pattern_byte <= c;
    in_data.is_regex     <= rx;
    in_data.last_byte    <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Send a whole pattern given as text.
  task automatic send_text(input string s, input logic rx);
    for (int i = 0; i < s.len(); i++) begin
      send_pattern_byte(s[i], rx, i == s.len() - 1);
    end
  endtask

  // Stop offering and wait until every report is out and the block is quiet.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write the threshold register while nothing is in flight.
  task automatic set_min_run_length(input logic [10:0] value);
    settle();
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  function automatic logic [7:0] rand_letter();
    return 8'h61 + 8'($urandom_range(0, 25));
  endfunction

  // Mostly letters and syntax characters, a few bars and some raw bytes.
  function automatic logic [7:0] pick_byte();
    logic [7:0] syntax_chars[14];
    int unsigned r;
    syntax_chars = '{CH_BACKSLASH, CH_LBRACKET, CH_RBRACKET, CH_LPAREN, CH_RPAREN,
                     CH_QUESTION, CH_STAR, CH_LBRACE, CH_RBRACE, CH_DOT, CH_PLUS,
                     CH_CARET, CH_DOLLAR, CH_SLASH};
    r = $urandom_range(0, 99);
    if (r < 50) begin
      return rand_letter();
    end else if (r < 82) begin
      return syntax_chars[$urandom_range(0, 13)];
    end else if (r < 85) begin
      return CH_BAR;
    end
    return 8'($urandom_range(0, 255));
  endfunction

  // Short patterns dominate; a few run to a hundred bytes or so.
  function automatic int unsigned pick_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) begin
      return $urandom_range(1, 12);
    end else if (r < 95) begin
      return $urandom_range(13, 40);
    end
    return $urandom_range(41, 120);
  endfunction

  task automatic send_random_pattern(input int unsigned len);
    logic rx;
    rx = ($urandom_range(0, 9) < 7);
    for (int unsigned i = 0; i < len; i++) begin
      send_pattern_byte(pick_byte(), rx, i == len - 1);
    end
  endtask

  // Receiver: ready and idle bursts, plus one long hold on request.
  initial begin
    while (rst) @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        hold_active  = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_active  = 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat (rx_idle_on ? $urandom_range(1, 20) : 1) @(posedge clk);
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    logic [10:0] thresholds[6];
    int unsigned phase_items[6];
    int unsigned sent;
    int unsigned len;
    thresholds  = '{11'd0, 11'd1023, 11'd1, 11'd1024, 11'd2, 11'd4};
    phase_items = '{60, 40, 60, 40, 60, 60};

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Hand-picked patterns under the reset threshold.
    send_text("a\\", 1'b1);
    send_text("ab|cd", 1'b1);
    send_text(")xyz", 1'b1);
    send_pattern_byte(8'h00, 1'b0, 1'b0);
    send_pattern_byte(8'hFF, 1'b0, 1'b1);
    send_text("(b)cd*", 1'b1);
    send_text("[a|b]x", 1'b1);

    // Hold the receiver off while short patterns keep coming, so the block
    // fills up and stops taking beats.
    hold_request = 1'b1;
    while (!hold_active) @(posedge clk);
    tx_idle_on = 1'b0;
    for (int i = 0; i < 10; i++) begin
      send_random_pattern(4);
    end
    tx_idle_on = 1'b1;

    for (int p = 0; p < 6; p++) begin
      if (p == 5) begin
        // Final stretch without idling on either side.
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;

        // A pattern one byte over the limit.
        for (int i = 0; i <= MAX_LEN; i++) begin
          send_pattern_byte(($urandom_range(0, 15) == 0) ? CH_DOT : rand_letter(),
                            1'b1, i == MAX_LEN);
        end
      end
      set_min_run_length(thresholds[p]);
      sent = 0;
      while (sent < phase_items[p]) begin
        len = pick_len();
        send_random_pattern(len);
        sent += len;
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("longest_literal_run_finder regression: pass");
    end else begin
      $display("longest_literal_run_finder regression: fail");
    end
    $finish;
  end

  // Watchdog for a block that hangs.
  initial begin
    #(TIMEOUT);
    $display("longest_literal_run_finder regression: fail");
    $finish;
  end

endmodule

// ----- longest_literal_run_finder.f -----
sv/llrf_pkg.sv
sv/llrf_front.sv
sv/llrf_queue.sv
sv/llrf_back.sv
sv/longest_literal_run_finder.sv
tb/llrf_checker.sv
tb/tb_longest_literal_run_finder.sv
